FILE: hw/rtl/spv_pkg.sv
// Shared types, constants and command/status structs of the sample preview voice.
`timescale 1ns / 1ps
package spv_pkg;

    localparam int DEF_FRAME_DEPTH = 65536;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam logic [16:0] UNITY = 17'd65536;

    // item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_PHASE_STEP = 3'd0;
    localparam logic [2:0] CFG_GAIN_SLEW  = 3'd1;
    localparam logic [2:0] CFG_FADE_SCALE = 3'd2;
    localparam logic [2:0] CFG_LENGTH     = 3'd3;
    localparam logic [2:0] CFG_STEREO     = 3'd4;

    localparam logic [19:0] RST_PHASE_STEP = 20'd65536;
    localparam logic [16:0] RST_GAIN_SLEW  = 17'd496;
    localparam logic [16:0] RST_FADE_SCALE = 17'd683;

    // shared multiplier and magnitude widths
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int MAG_W   = 40;
    localparam int HALF_W  = MAG_W / 2;
    localparam int ACC_W   = 64;
    localparam int ADDR_IN_W = 17;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_FH_S,
        MUL_FL_S,
        MUL_D_FRAC,
        MUL_VH_G,
        MUL_VL_G,
        MUL_TH_F,
        MUL_TL_F
    } mul_sel_t;

    typedef enum logic [3:0] {
        POST_NONE,
        POST_WRITE,
        POST_CHECK,
        POST_CAP_A,
        POST_CAP_B,
        POST_ACC17,
        POST_FADE,
        POST_V,
        POST_ACC20,
        POST_T,
        POST_O
    } post_t;

    typedef enum logic [1:0] {
        REM_ADDR,
        REM_A,
        REM_B
    } rem_sel_t;

    typedef struct packed {
        logic     take;
        logic     rem_start;
        rem_sel_t rem_sel;
        logic     rd_en;
        mul_sel_t mul;
        post_t    post;
        logic     chan;
        logic     out_load;
    } spv_cmd_t;

    typedef struct packed {
        logic go;
        logic rem_busy;
        logic out_free;
    } spv_status_t;

endpackage

FILE: hw/rtl/spv_rem.sv
// Frame index reduction modulo the store depth: a mask for a power of two, else a reciprocal multiply.
`timescale 1ns / 1ps
module spv_rem #(
    parameter int FRAME_DEPTH = spv_pkg::DEF_FRAME_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [spv_pkg::ADDR_IN_W-1:0]  x,
    output logic                           busy,
    output logic [$clog2(FRAME_DEPTH)-1:0] idx
);
    import spv_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int RW = 25;
    localparam bit POW2 = (FRAME_DEPTH & (FRAME_DEPTH - 1)) == 0;
    localparam logic [RW-1:0] DEPTH_R = RW'(FRAME_DEPTH);
    localparam logic [RW-1:0] MASK_R  = RW'(FRAME_DEPTH - 1);
    // x / depth == (x * RECIP) >> SH exactly for every x below 2**ADDR_IN_W
    localparam int SH = ADDR_IN_W + AW;
    localparam int MW = ADDR_IN_W + 2;
    localparam int PW = ADDR_IN_W + MW;
    localparam int QW = ADDR_IN_W + RW;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SH) + 64'(FRAME_DEPTH) - 64'd1) / 64'(FRAME_DEPTH);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

    logic [RW-1:0]        rem_reg;
    logic [ADDR_IN_W-1:0] x_reg;
    logic [PW-1:0]        prod_reg;
    logic                 busy_reg;
    logic [PW-1:0]        q_full;
    logic [QW-1:0]        qd;
    logic [QW-1:0]        r_raw;

    always_comb
    begin
        q_full = prod_reg >> SH;
        qd     = QW'(q_full[ADDR_IN_W-1:0]) * QW'(DEPTH_R);
        r_raw  = QW'(x_reg) - qd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rem_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= !POW2;
            if (POW2)
                rem_reg <= RW'(x) & MASK_R;
        end
        else if (busy_reg)
        begin
            busy_reg <= 1'b0;
            rem_reg  <= r_raw[RW-1:0];
        end
    end

    // quotient estimate in the start cycle, remainder in the next
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x;
            prod_reg <= x * RECIP;
        end
    end

    assign busy = busy_reg;
    assign idx  = rem_reg[AW-1:0];

    a_rem_below_depth: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> rem_reg < DEPTH_R)
        else $error("frame index reduction out of range");

    a_rem_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start |=> !busy_reg)
        else $error("frame index reduction overran");

    a_rem_pow2_fast: assert property (@(posedge clk) disable iff (!rst_n)
        start && POW2 |=> !busy_reg)
        else $error("power of two depth should reduce at once");

endmodule

FILE: hw/rtl/spv_datapath.sv
// Datapath: config registers, voice state, frame store, shared multiplier and output register.
`timescale 1ns / 1ps
module spv_datapath #(
    parameter int FRAME_DEPTH = spv_pkg::DEF_FRAME_DEPTH,
    parameter int SAMPLE_BITS = spv_pkg::DEF_SAMPLE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [19:0]           cfg_data,
    input  logic [1:0]            kind,
    input  logic [15:0]           frame_address,
    input  logic signed [15:0]    left_in,
    input  logic signed [15:0]    right_in,
    input  logic [16:0]           target_gain,
    input  spv_pkg::spv_cmd_t     cmd,
    output spv_pkg::spv_status_t  status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic signed [15:0]    left_out,
    output logic signed [15:0]    right_out,
    output logic                  active
);
    import spv_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(FRAME_DEPTH);
    localparam logic signed [23:0] S_HI = 24'sd2 ** (SB - 1) - 24'sd1;
    localparam logic signed [23:0] S_LO = -S_HI - 24'sd1;

    function automatic logic [SB-1:0] sat_sample(input logic signed [15:0] x);
        logic signed [23:0] xe;
        logic signed [23:0] r;
        xe = 24'(x);
        if (xe > S_HI)
            r = S_HI;
        else if (xe < S_LO)
            r = S_LO;
        else
            r = xe;
        return r[SB-1:0];
    endfunction

    // configuration
    logic [19:0] phase_step_reg;
    logic [16:0] gain_slew_reg;
    logic [16:0] fade_scale_reg;
    logic [16:0] len_reg;
    logic        stereo_reg;

    // voice state
    logic [32:0] pos_reg;
    logic [16:0] gain_reg;
    logic        stop_reg;
    logic        active_reg;

    // latched item
    logic [15:0]        addr_reg;
    logic signed [15:0] l_in_reg;
    logic signed [15:0] r_in_reg;
    logic [16:0]        tg_reg;

    // per tick working set
    logic [16:0]       a_reg;
    logic [16:0]       b_reg;
    logic [15:0]       frac_reg;
    logic [32:0]       fd_reg;
    logic [2*SB-1:0]   sa_reg;
    logic [2*SB-1:0]   sb_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [16:0]       fade_reg;
    logic              vneg_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic signed [15:0] res_l_reg;
    logic signed [15:0] res_r_reg;

    logic               out_valid_reg;
    logic signed [15:0] left_out_reg;
    logic signed [15:0] right_out_reg;
    logic               active_out_reg;

    logic [2*SB-1:0] mem [FRAME_DEPTH];
    logic [2*SB-1:0] rd_data_reg;

    // index reduction
    logic [ADDR_IN_W-1:0] rem_x;
    logic                 rem_busy;
    logic [AW-1:0]        rem_idx;

    always_comb
    begin
        case (cmd.rem_sel)
            REM_A:   rem_x = a_reg;
            REM_B:   rem_x = b_reg;
            default: rem_x = {1'b0, addr_reg};
        endcase
    end

    spv_rem #(.FRAME_DEPTH(FRAME_DEPTH)) u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.rem_start),
        .x     (rem_x),
        .busy  (rem_busy),
        .idx   (rem_idx)
    );

    // tick entry arithmetic
    logic [16:0]        a_cur;
    logic               ending;
    logic               go;
    logic [17:0]        a_inc;
    logic [16:0]        b_cur;
    logic [32:0]        fd_cur;
    logic [16:0]        tg_c;
    logic [16:0]        target;
    logic signed [18:0] diff;
    logic signed [18:0] lim;
    logic signed [18:0] diff_c;
    logic signed [18:0] gain_sum;
    logic [33:0]        pos_sum;
    logic [32:0]        pos_new;

    always_comb
    begin
        a_cur  = pos_reg[32:16];
        ending = (a_cur >= len_reg) || (stop_reg && gain_reg == '0);
        go     = active_reg && !ending;
        a_inc  = {1'b0, a_cur} + 18'd1;
        b_cur  = (a_inc < {1'b0, len_reg}) ? a_inc[16:0] : len_reg - 17'd1;
        fd_cur = {len_reg, 16'b0} - pos_reg;
        tg_c   = (tg_reg > UNITY) ? UNITY : tg_reg;
        target = stop_reg ? 17'd0 : tg_c;
        diff   = $signed({2'b0, target}) - $signed({2'b0, gain_reg});
        lim    = $signed({2'b0, gain_slew_reg});
        if (diff > lim)
            diff_c = lim;
        else if (diff < -lim)
            diff_c = -lim;
        else
            diff_c = diff;
        gain_sum = $signed({2'b0, gain_reg}) + diff_c;
        pos_sum  = {1'b0, pos_reg} + 34'(phase_step_reg);
        pos_new  = pos_sum[33] ? '1 : pos_sum[32:0];
    end

    // channel samples
    logic signed [SB-1:0] sa_ch;
    logic signed [SB-1:0] sb_ch;
    logic signed [SB:0]   d_ch;

    always_comb
    begin
        if (cmd.chan && stereo_reg)
        begin
            sa_ch = sa_reg[2*SB-1:SB];
            sb_ch = sb_reg[2*SB-1:SB];
        end
        else
        begin
            sa_ch = sa_reg[SB-1:0];
            sb_ch = sb_reg[SB-1:0];
        end
        d_ch = $signed({sb_ch[SB-1], sb_ch}) - $signed({sa_ch[SB-1], sa_ch});
    end

    // shared multiplier operands
    logic signed [MUL_A_W-1:0] ma;
    logic signed [MUL_B_W-1:0] mb;

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.mul)
            MUL_FH_S:
            begin
                ma = $signed(MUL_A_W'(fd_reg[32:17]));
                mb = $signed({1'b0, fade_scale_reg});
            end
            MUL_FL_S:
            begin
                ma = $signed(MUL_A_W'(fd_reg[16:0]));
                mb = $signed({1'b0, fade_scale_reg});
            end
            MUL_D_FRAC:
            begin
                ma = {{(MUL_A_W-SB-1){d_ch[SB]}}, d_ch};
                mb = $signed({2'b0, frac_reg});
            end
            MUL_VH_G:
            begin
                ma = $signed(MUL_A_W'(mag_reg[MAG_W-1:HALF_W]));
                mb = $signed({1'b0, gain_reg});
            end
            MUL_VL_G:
            begin
                ma = $signed(MUL_A_W'(mag_reg[HALF_W-1:0]));
                mb = $signed({1'b0, gain_reg});
            end
            MUL_TH_F:
            begin
                ma = $signed(MUL_A_W'(mag_reg[MAG_W-1:HALF_W]));
                mb = $signed({1'b0, fade_reg});
            end
            MUL_TL_F:
            begin
                ma = $signed(MUL_A_W'(mag_reg[HALF_W-1:0]));
                mb = $signed({1'b0, fade_reg});
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // post processing of the previous product
    logic [ACC_W-1:0]         prod_u;
    logic [ACC_W-1:0]         sum64;
    logic signed [PROD_W-1:0] v_full;
    logic signed [PROD_W-1:0] v_abs;
    logic [31:0]              o_mag;
    logic signed [15:0]       o_res;

    always_comb
    begin
        prod_u = {{(ACC_W-PROD_W+1){1'b0}}, prod_reg[PROD_W-2:0]};
        sum64  = acc_reg + prod_u;
        v_full = $signed({{(PROD_W-16-SB){sa_ch[SB-1]}}, sa_ch, 16'b0}) + prod_reg;
        v_abs  = v_full[PROD_W-1] ? -v_full : v_full;
        o_mag  = sum64[63:32];
        if (vneg_reg)
            o_res = (o_mag >= 32'd32768) ? 16'sh8000 : $signed(-o_mag[15:0]);
        else
            o_res = (o_mag >= 32'd32767) ? 16'sh7FFF : $signed(o_mag[15:0]);
    end

    // configuration and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= RST_PHASE_STEP;
            gain_slew_reg  <= RST_GAIN_SLEW;
            fade_scale_reg <= RST_FADE_SCALE;
            len_reg        <= '0;
            stereo_reg     <= 1'b0;
            pos_reg        <= '0;
            gain_reg       <= '0;
            stop_reg       <= 1'b0;
            active_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PHASE_STEP: phase_step_reg <= cfg_data;
                    CFG_GAIN_SLEW:  gain_slew_reg  <= cfg_data[16:0];
                    CFG_FADE_SCALE: fade_scale_reg <= cfg_data[16:0];
                    CFG_LENGTH:     len_reg        <= cfg_data[16:0];
                    CFG_STEREO:     stereo_reg     <= cfg_data[0];
                    default:        ;
                endcase
            end
            if (cmd.take && kind == KIND_START && len_reg != '0)
            begin
                pos_reg    <= '0;
                gain_reg   <= '0;
                stop_reg   <= 1'b0;
                active_reg <= 1'b1;
            end
            else if (cmd.take && kind == KIND_STOP)
                stop_reg <= 1'b1;
            if (cmd.post == POST_CHECK)
            begin
                if (go)
                begin
                    gain_reg <= gain_sum[16:0];
                    pos_reg  <= pos_new;
                end
                else
                    active_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            addr_reg <= frame_address;
            l_in_reg <= left_in;
            r_in_reg <= right_in;
            tg_reg   <= target_gain;
        end
        prod_reg <= ma * mb;
        case (cmd.post)
            POST_CHECK:
            begin
                a_reg     <= a_cur;
                b_reg     <= b_cur;
                frac_reg  <= pos_reg[15:0];
                fd_reg    <= fd_cur;
                res_l_reg <= '0;
                res_r_reg <= '0;
            end
            POST_CAP_A: sa_reg <= rd_data_reg;
            POST_CAP_B: sb_reg <= rd_data_reg;
            POST_ACC17: acc_reg <= prod_u << 17;
            POST_FADE:  fade_reg <= (sum64[63:16] > 48'(UNITY)) ? UNITY : sum64[32:16];
            POST_V:
            begin
                vneg_reg <= v_full[PROD_W-1];
                mag_reg  <= v_abs[MAG_W-1:0];
            end
            POST_ACC20: acc_reg <= prod_u << HALF_W;
            POST_T:     mag_reg <= sum64[MAG_W+15:16];
            POST_O:
            begin
                if (cmd.chan)
                    res_r_reg <= o_res;
                else
                    res_l_reg <= o_res;
            end
            default: ;
        endcase
    end

    // frame store
    always_ff @(posedge clk)
    begin
        if (cmd.post == POST_WRITE)
            mem[rem_idx] <= {sat_sample(r_in_reg), sat_sample(l_in_reg)};
        if (cmd.rd_en)
            rd_data_reg <= mem[rem_idx];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            left_out_reg   <= res_l_reg;
            right_out_reg  <= res_r_reg;
            active_out_reg <= active_reg;
        end
    end

    assign status.go       = go;
    assign status.rem_busy = rem_busy;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;
    assign active    = active_out_reg;

    a_gain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= UNITY)
        else $error("smoothed gain above unity");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_zero_len_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && kind == KIND_START && len_reg == '0 && !active_reg |=> !active_reg)
        else $error("start with zero length armed the voice");

    a_stop_gain_falls: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post == POST_CHECK && go && stop_reg |=> gain_reg <= $past(gain_reg))
        else $error("gain rose while stopping");

endmodule

FILE: hw/rtl/spv_ctrl.sv
// Controller state machine that sequences write, start, stop and tick items.
`timescale 1ns / 1ps
module spv_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           kind,
    output logic                 in_ready,
    input  spv_pkg::spv_status_t status,
    output spv_pkg::spv_cmd_t    cmd
);
    import spv_pkg::*;

    typedef enum logic [20:0] {
        S_IDLE    = 21'h000001,
        S_WR_REM  = 21'h000002,
        S_WR_WAIT = 21'h000004,
        S_WRITE   = 21'h000008,
        S_CHECK   = 21'h000010,
        S_A_REM   = 21'h000020,
        S_A_WAIT  = 21'h000040,
        S_B_REM   = 21'h000080,
        S_B_WAIT  = 21'h000100,
        S_FADE1   = 21'h000200,
        S_FADE2   = 21'h000400,
        S_FADE3   = 21'h000800,
        S_C1      = 21'h001000,
        S_C2      = 21'h002000,
        S_C3      = 21'h004000,
        S_C4      = 21'h008000,
        S_C5      = 21'h010000,
        S_C6      = 21'h020000,
        S_C7      = 21'h040000,
        S_C8      = 21'h080000,
        S_OUT     = 21'h100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   chan_reg;
    logic   chan_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chan_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        cmd        = '0;
        cmd.chan   = chan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = in_valid;
                if (in_valid)
                begin
                    if (kind == KIND_WRITE)
                        state_next = S_WR_REM;
                    else if (kind == KIND_TICK)
                        state_next = S_CHECK;
                end
            end
            S_WR_REM:
            begin
                cmd.rem_start = 1'b1;
                cmd.rem_sel   = REM_ADDR;
                state_next    = S_WR_WAIT;
            end
            S_WR_WAIT:
            begin
                if (!status.rem_busy)
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.post   = POST_WRITE;
                state_next = S_IDLE;
            end
            S_CHECK:
            begin
                cmd.post   = POST_CHECK;
                state_next = status.go ? S_A_REM : S_OUT;
            end
            S_A_REM:
            begin
                cmd.rem_start = 1'b1;
                cmd.rem_sel   = REM_A;
                state_next    = S_A_WAIT;
            end
            S_A_WAIT:
            begin
                if (!status.rem_busy)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_B_REM;
                end
            end
            S_B_REM:
            begin
                cmd.rem_start = 1'b1;
                cmd.rem_sel   = REM_B;
                cmd.post      = POST_CAP_A;
                state_next    = S_B_WAIT;
            end
            S_B_WAIT:
            begin
                if (!status.rem_busy)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_FADE1;
                end
            end
            S_FADE1:
            begin
                cmd.mul    = MUL_FH_S;
                cmd.post   = POST_CAP_B;
                state_next = S_FADE2;
            end
            S_FADE2:
            begin
                cmd.mul    = MUL_FL_S;
                cmd.post   = POST_ACC17;
                state_next = S_FADE3;
            end
            S_FADE3:
            begin
                cmd.post   = POST_FADE;
                chan_next  = 1'b0;
                state_next = S_C1;
            end
            S_C1:
            begin
                cmd.mul    = MUL_D_FRAC;
                state_next = S_C2;
            end
            S_C2:
            begin
                cmd.post   = POST_V;
                state_next = S_C3;
            end
            S_C3:
            begin
                cmd.mul    = MUL_VH_G;
                state_next = S_C4;
            end
            S_C4:
            begin
                cmd.mul    = MUL_VL_G;
                cmd.post   = POST_ACC20;
                state_next = S_C5;
            end
            S_C5:
            begin
                cmd.post   = POST_T;
                state_next = S_C6;
            end
            S_C6:
            begin
                cmd.mul    = MUL_TH_F;
                state_next = S_C7;
            end
            S_C7:
            begin
                cmd.mul    = MUL_TL_F;
                cmd.post   = POST_ACC20;
                state_next = S_C8;
            end
            S_C8:
            begin
                cmd.post = POST_O;
                if (chan_reg)
                    state_next = S_OUT;
                else
                begin
                    chan_next  = 1'b1;
                    state_next = S_C1;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready = state_reg == S_IDLE;

    a_tick_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK && !status.go |=> state_reg == S_OUT)
        else $error("ending tick lost its result");

    a_write_after_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRITE |-> $past(state_reg) == S_WR_WAIT && !$past(status.rem_busy))
        else $error("store written before index reduced");

    a_both_channels: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && $past(state_reg) == S_C8 |-> $past(chan_reg))
        else $error("result loaded before right channel");

endmodule

FILE: hw/rtl/sample_preview_voice_top.sv
// Top level of the one-voice sample player: controller plus datapath.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready) carries one item: kind selects a frame write
//   (frame_address, left_in, right_in), a start, a stop, or a tick (target_gain).
//   Only a tick yields a result on the output channel (out_valid/out_ready):
//   left_out, right_out and active.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write it only
//   while no item is in flight.
// Sequencing:
//   Start and stop are taken in the idle state. A write reduces its frame index and then
//   writes the store. For a playing tick the two channels go through 8 steps each on one
//   shared 26x18 multiplier, after the index reduction, store reads and fade.
//   An ending or idle tick goes from its check straight to the output register. When
//   FRAME_DEPTH is not a power of two every store index is reduced by a reciprocal
//   multiply whose remainder is registered after its quotient estimate.
// Reset clears the configuration to defaults and stops the voice; the frame store is
// not cleared. A result waits in the output register while out_ready is low; the
// block takes further non-tick items meanwhile and holds a new tick until it drains.
module sample_preview_voice_top #(
    parameter int FRAME_DEPTH = spv_pkg::DEF_FRAME_DEPTH,
    parameter int SAMPLE_BITS = spv_pkg::DEF_SAMPLE_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [15:0]        frame_address,
    input  logic signed [15:0] left_in,
    input  logic signed [15:0] right_in,
    input  logic [16:0]        target_gain,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    output logic               active
);
    import spv_pkg::*;

    spv_cmd_t    cmd;
    spv_status_t status;

    spv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    spv_datapath #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .kind          (kind),
        .frame_address (frame_address),
        .left_in       (left_in),
        .right_in      (right_in),
        .target_gain   (target_gain),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .left_out      (left_out),
        .right_out     (right_out),
        .active        (active)
    );

endmodule
